// ===== sv/hts2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts2_pkg
// Shared types, constants and lookup functions for the HID to PS/2 set 2
// scan code translator.
// ----------------------------------------------------------------------------
package hts2_pkg;

	// Event kinds on the command input.
	localparam logic CMD_KEY_DOWN = 1'b0;
	localparam logic CMD_KEY_UP   = 1'b1;

	// Set 2 prefix bytes.
	localparam logic [7:0] PREFIX_EXT   = 8'hE0;
	localparam logic [7:0] PREFIX_BREAK = 8'hF0;

	// Modifier bits whose codes carry the extended prefix (LGUI, RCTRL, RALT, RGUI).
	localparam logic [7:0] MOD_EXT_MASK = 8'hD8;

	// Default depth of the job queue between the front and back parts.
	localparam int JOB_DEPTH_DEFAULT = 2;

	// Sub-step inside the emission of one code sequence.
	typedef enum logic [1:0] {
		SUB_E0,
		SUB_F0,
		SUB_CODE
	} sub_t;

	// One classified event, handed from the front to the back.
	typedef struct packed {
		logic       key_up;
		logic       key_valid;
		logic       key_ext;
		logic [7:0] key_code;
		logic [7:0] diff;
		logic [7:0] mods;
	} job_t;

	// Key table entry: bit 8 marks an extended key, zero means unmapped.
	typedef logic [8:0] key_entry_t;

	// Make code of each modifier bit, without the extended prefix.
	function automatic logic [7:0] mod_code(input logic [2:0] idx);
		logic [7:0] code;
		unique case (idx)
			3'd0: code = 8'h14;
			3'd1: code = 8'h12;
			3'd2: code = 8'h11;
			3'd3: code = 8'h1F;
			3'd4: code = 8'h14;
			3'd5: code = 8'h59;
			3'd6: code = 8'h11;
			3'd7: code = 8'h27;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// HID usage ID to set 2 make code.
	function automatic key_entry_t usage_map(input logic [7:0] usage);
		key_entry_t e;
		unique case (usage)
			8'h04: e = 9'h01C; 8'h05: e = 9'h032; 8'h06: e = 9'h021; 8'h07: e = 9'h023;
			8'h08: e = 9'h024; 8'h09: e = 9'h02B; 8'h0A: e = 9'h034; 8'h0B: e = 9'h033;
			8'h0C: e = 9'h043; 8'h0D: e = 9'h03B; 8'h0E: e = 9'h042; 8'h0F: e = 9'h04B;
			8'h10: e = 9'h03A; 8'h11: e = 9'h031; 8'h12: e = 9'h044; 8'h13: e = 9'h04D;
			8'h14: e = 9'h015; 8'h15: e = 9'h02D; 8'h16: e = 9'h01B; 8'h17: e = 9'h02C;
			8'h18: e = 9'h03C; 8'h19: e = 9'h02A; 8'h1A: e = 9'h01D; 8'h1B: e = 9'h022;
			8'h1C: e = 9'h035; 8'h1D: e = 9'h01A;
			8'h1E: e = 9'h016; 8'h1F: e = 9'h01E; 8'h20: e = 9'h026; 8'h21: e = 9'h025;
			8'h22: e = 9'h02E; 8'h23: e = 9'h036; 8'h24: e = 9'h03D; 8'h25: e = 9'h03E;
			8'h26: e = 9'h046; 8'h27: e = 9'h045;
			8'h28: e = 9'h05A; 8'h29: e = 9'h076; 8'h2A: e = 9'h066; 8'h2B: e = 9'h00D;
			8'h2C: e = 9'h029; 8'h2D: e = 9'h04E; 8'h2E: e = 9'h055; 8'h2F: e = 9'h054;
			8'h30: e = 9'h05B; 8'h31: e = 9'h05D;
			8'h33: e = 9'h04C; 8'h34: e = 9'h052; 8'h35: e = 9'h00E; 8'h36: e = 9'h041;
			8'h37: e = 9'h049; 8'h38: e = 9'h04A; 8'h39: e = 9'h058;
			8'h3A: e = 9'h005; 8'h3B: e = 9'h006; 8'h3C: e = 9'h004; 8'h3D: e = 9'h00C;
			8'h3E: e = 9'h003; 8'h3F: e = 9'h00B; 8'h40: e = 9'h083; 8'h41: e = 9'h00A;
			8'h42: e = 9'h001; 8'h43: e = 9'h009; 8'h44: e = 9'h078; 8'h45: e = 9'h007;
			8'h49: e = 9'h170; 8'h4A: e = 9'h16C; 8'h4B: e = 9'h17D; 8'h4C: e = 9'h171;
			8'h4D: e = 9'h169; 8'h4E: e = 9'h17A; 8'h4F: e = 9'h174; 8'h50: e = 9'h16B;
			8'h51: e = 9'h172; 8'h52: e = 9'h175;
			8'h53: e = 9'h077; 8'h54: e = 9'h14A; 8'h55: e = 9'h07C; 8'h56: e = 9'h07B;
			8'h57: e = 9'h079; 8'h58: e = 9'h15A;
			8'h59: e = 9'h069; 8'h5A: e = 9'h072; 8'h5B: e = 9'h07A; 8'h5C: e = 9'h06B;
			8'h5D: e = 9'h073; 8'h5E: e = 9'h074; 8'h5F: e = 9'h06C; 8'h60: e = 9'h075;
			8'h61: e = 9'h07D; 8'h62: e = 9'h070; 8'h63: e = 9'h071;
			default: e = 9'h000;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// ===== sv/hts2_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts2_front
// Accepts events, tracks the held modifier mask and classifies each event
// into a job for the back part.
// ----------------------------------------------------------------------------
module hts2_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          command,
	input  wire logic [7:0]    key_usage,
	input  wire logic [7:0]    modifier_bits,
	input  wire logic          job_full,
	output hts2_pkg::job_t     job,
	output logic               job_push
);

	logic                  accept;
	logic [7:0]            held_q;
	hts2_pkg::key_entry_t  entry;

	assign accept = push && !job_full;
	assign entry  = hts2_pkg::usage_map(key_usage);

	// Classify the event into what the back part has to emit.
	always_comb begin
		job.key_up    = (command == hts2_pkg::CMD_KEY_UP);
		job.key_valid = (entry[7:0] != 8'h00);
		job.key_ext   = entry[8];
		job.key_code  = entry[7:0];
		job.diff      = modifier_bits ^ held_q;
		job.mods      = modifier_bits;
	end

	// Events that emit nothing only update the held mask.
	assign job_push = accept && (job.key_valid || (job.diff != 8'h00));

	// Held modifier mask follows every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'h00;
		end else if (accept) begin
			held_q <= modifier_bits;
		end
	end

endmodule
`default_nettype wire

// ===== sv/hts2_job_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts2_job_fifo
// Small flop-based queue of classified jobs between the front and back.
// ----------------------------------------------------------------------------
module hts2_job_fifo #(
	parameter int DEPTH = hts2_pkg::JOB_DEPTH_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire hts2_pkg::job_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output hts2_pkg::job_t     rd_data,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hts2_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/hts2_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts2_back
// Sequences one job into set 2 bytes into an output register that the
// receiver drains, one byte per cycle while the receiver keeps popping.
// ----------------------------------------------------------------------------
module hts2_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hts2_pkg::job_t job,
	input  wire logic          job_empty,
	output logic               job_pop,
	output logic [7:0]         scan_byte,
	output logic               last_byte,
	output logic               empty,
	input  wire logic          pop
);

	logic            active_q;
	logic            key_up_q;
	logic            key_pend_q;
	logic            key_ext_q;
	logic [7:0]      key_code_q;
	logic [7:0]      diff_q;
	logic [7:0]      mods_q;
	hts2_pkg::sub_t  sub_q;

	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            key_unit;
	logic [7:0]      mod_onehot;
	logic [2:0]      mod_idx;
	logic            ext;
	logic            rel;
	logic [7:0]      code;
	hts2_pkg::sub_t  stage;
	hts2_pkg::sub_t  stage_next;
	logic [7:0]      cur_byte;
	logic            unit_done;
	logic [7:0]      diff_after;
	logic            key_after;
	logic            is_last;
	logic            emit;
	logic            out_xfer;

	// Pick the current unit: the key or the lowest changed modifier.
	always_comb begin
		key_unit   = key_pend_q && (key_up_q || (diff_q == 8'h00));
		mod_onehot = diff_q & (~diff_q + 8'h01);
		mod_idx    = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (diff_q[i]) begin
				mod_idx = 3'(i);
			end
		end
		ext  = key_unit ? key_ext_q : |(mod_onehot & hts2_pkg::MOD_EXT_MASK);
		rel  = key_unit ? key_up_q : ~|(mod_onehot & mods_q);
		code = key_unit ? key_code_q : hts2_pkg::mod_code(mod_idx);
	end

	// Skip prefixes that this unit does not use, then form the byte.
	always_comb begin
		stage = sub_q;
		if (stage == hts2_pkg::SUB_E0 && !ext) begin
			stage = hts2_pkg::SUB_F0;
		end
		if (stage == hts2_pkg::SUB_F0 && !rel) begin
			stage = hts2_pkg::SUB_CODE;
		end
		unique case (stage)
			hts2_pkg::SUB_E0: begin
				cur_byte   = hts2_pkg::PREFIX_EXT;
				stage_next = hts2_pkg::SUB_F0;
			end
			hts2_pkg::SUB_F0: begin
				cur_byte   = hts2_pkg::PREFIX_BREAK;
				stage_next = hts2_pkg::SUB_CODE;
			end
			default: begin
				cur_byte   = code;
				stage_next = hts2_pkg::SUB_E0;
			end
		endcase
		unit_done  = (stage == hts2_pkg::SUB_CODE);
		diff_after = key_unit ? diff_q : (diff_q & ~mod_onehot);
		key_after  = key_unit ? 1'b0 : key_pend_q;
		is_last    = unit_done && (diff_after == 8'h00) && !key_after;
	end

	assign out_xfer = pop && out_valid_q;
	assign emit     = active_q && (!out_valid_q || pop);
	assign job_pop  = !active_q && !job_empty;

	// Sequencer state: load a job when idle, advance one byte per emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			key_pend_q <= 1'b0;
			diff_q     <= 8'h00;
			sub_q      <= hts2_pkg::SUB_E0;
		end else if (job_pop) begin
			active_q   <= 1'b1;
			key_pend_q <= job.key_valid;
			diff_q     <= job.diff;
			sub_q      <= hts2_pkg::SUB_E0;
		end else if (emit) begin
			sub_q <= stage_next;
			if (unit_done) begin
				diff_q     <= diff_after;
				key_pend_q <= key_after;
			end
			if (is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	// Job payload held for the length of the sequence.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			key_up_q   <= job.key_up;
			key_ext_q  <= job.key_ext;
			key_code_q <= job.key_code;
			mods_q     <= job.mods;
		end
	end

	// Output register; refilled in the same cycle it is drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign scan_byte = out_byte_q;
	assign last_byte = out_last_q;
	assign empty     = !out_valid_q;

endmodule
`default_nettype wire

// ===== sv/hid_to_ps2_set2_scancode_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hid_to_ps2_set2_scancode_core
// Translates HID key events with a modifier mask into a PS/2 scan code set 2
// byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive command, key_usage and modifier_bits with push high;
//   a transfer happens on a clock edge where full is low. The front tracks
//   the held modifier mask and queues a job per event that emits bytes.
//   Output channel: while empty is low, scan_byte and last_byte show the
//   oldest byte; pop high on a clock edge transfers it. last_byte marks the
//   final byte of an event. Events that emit nothing produce no bytes.
// Flow:
//   The first byte of an event passes through the job queue and the back
//   part's job registers before it reaches the output register. The back
//   part loads each job before its first byte, then emits one byte per cycle
//   while pop keeps the output drained. The front accepts one event per cycle
//   until the job queue of JOB_DEPTH entries is full.
// Reset:
//   arst_n clears the held modifier mask, the job queue and the output.
// Stalls:
//   When pop stays low the byte holds, the sequencer waits, then the queue
//   fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module hid_to_ps2_set2_scancode_core #(
	parameter int JOB_DEPTH = hts2_pkg::JOB_DEPTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       command,
	input  wire logic [7:0] key_usage,
	input  wire logic [7:0] modifier_bits,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      scan_byte,
	output logic            last_byte
);

	hts2_pkg::job_t  front_job;
	hts2_pkg::job_t  back_job;
	logic            job_push;
	logic            job_pop;
	logic            job_empty;

	// Front: accept and classify.
	hts2_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.command       (command),
		.key_usage     (key_usage),
		.modifier_bits (modifier_bits),
		.job_full      (full),
		.job           (front_job),
		.job_push      (job_push)
	);

	// Queue between the two parts.
	hts2_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (front_job),
		.full    (full),
		.rd_en   (job_pop),
		.rd_data (back_job),
		.empty   (job_empty)
	);

	// Back: byte sequencer and output register.
	hts2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.scan_byte (scan_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

// ===== sim/tb_hid_to_ps2_set2_scancode_core.sv =====
// ----------------------------------------------------------------------------
// tb_hid_to_ps2_set2_scancode_core
// Self-checking bench for the HID to PS/2 set 2 translator. A short table of
// directed key events runs first, followed by random press and release
// sequences mixed with raw noise. Every accepted event is run through a
// behavioral translator that keeps its own copy of the held modifier mask,
// and each output byte is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_hid_to_ps2_set2_scancode_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_EVENTS = 450;
	localparam int DIRECTED_ROWS = 22;
	localparam int MAX_REPORTS   = 10;

	// Local names for the package codes used throughout the bench.
	localparam logic       CMD_KEY_DOWN = hts2_pkg::CMD_KEY_DOWN;
	localparam logic       CMD_KEY_UP   = hts2_pkg::CMD_KEY_UP;
	localparam logic [7:0] PREFIX_EXT   = hts2_pkg::PREFIX_EXT;
	localparam logic [7:0] PREFIX_BREAK = hts2_pkg::PREFIX_BREAK;

	// One predicted output byte.
	typedef struct {
		logic [7:0] code;
		logic       last;
	} scan_t;

	// One row of the directed table. Rows with known set carry their bytes.
	typedef struct packed {
		logic       known;
		logic       cmd;
		logic [7:0] usage;
		logic [7:0] mods;
		logic [1:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} event_row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       command;
	logic [7:0] key_usage;
	logic [7:0] modifier_bits;
	logic       empty;
	logic       pop;
	logic [7:0] scan_byte;
	logic       last_byte;

	// Set 2 code per HID usage: bit 8 marks an extended key, zero is unmapped.
	logic [8:0] set2_code [100] = '{
		9'h000, 9'h000, 9'h000, 9'h000,
		9'h01C, 9'h032, 9'h021, 9'h023, 9'h024, 9'h02B, 9'h034, 9'h033,
		9'h043, 9'h03B, 9'h042, 9'h04B, 9'h03A, 9'h031, 9'h044, 9'h04D,
		9'h015, 9'h02D, 9'h01B, 9'h02C, 9'h03C, 9'h02A, 9'h01D, 9'h022,
		9'h035, 9'h01A,
		9'h016, 9'h01E, 9'h026, 9'h025, 9'h02E, 9'h036, 9'h03D, 9'h03E,
		9'h046, 9'h045,
		9'h05A, 9'h076, 9'h066, 9'h00D, 9'h029, 9'h04E, 9'h055, 9'h054,
		9'h05B, 9'h05D,
		9'h000, 9'h04C, 9'h052, 9'h00E, 9'h041, 9'h049, 9'h04A, 9'h058,
		9'h005, 9'h006, 9'h004, 9'h00C, 9'h003, 9'h00B, 9'h083, 9'h00A,
		9'h001, 9'h009, 9'h078, 9'h007,
		9'h000, 9'h000, 9'h000,
		9'h170, 9'h16C, 9'h17D, 9'h171, 9'h169, 9'h17A, 9'h174, 9'h16B,
		9'h172, 9'h175,
		9'h077, 9'h14A, 9'h07C, 9'h07B, 9'h079, 9'h15A,
		9'h069, 9'h072, 9'h07A, 9'h06B, 9'h073, 9'h074, 9'h06C, 9'h075,
		9'h07D, 9'h070, 9'h071
	};

	// Modifier make codes from bit 0 (left control) to bit 7 (right GUI).
	logic [7:0] mod_make [8] = '{
		8'h14, 8'h12, 8'h11, 8'h1F, 8'h14, 8'h59, 8'h11, 8'h27
	};

	// Directed events: corner usages, prefixes, modifier extremes, no-ops.
	event_row_t directed [DIRECTED_ROWS] = '{
		'{1'b1, CMD_KEY_DOWN, 8'h04, 8'h00, 2'd1, 8'h1C, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_UP,   8'h04, 8'h00, 2'd2, PREFIX_BREAK, 8'h1C, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'hFF, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h52, 8'h00, 2'd2, PREFIX_EXT, 8'h75, 8'h00},
		'{1'b1, CMD_KEY_UP,   8'h52, 8'h00, 2'd3, PREFIX_EXT, PREFIX_BREAK, 8'h75},
		'{1'b1, CMD_KEY_DOWN, 8'h32, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h64, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h63, 8'h00, 2'd1, 8'h71, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h40, 8'h00, 2'd1, 8'h83, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_DOWN, 8'h00, 8'h01, 2'd1, 8'h14, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_UP,   8'h00, 8'h01, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_DOWN, 8'h00, 8'hFF, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_UP,   8'h58, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_DOWN, 8'h2C, 8'h80, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_UP,   8'h2C, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_DOWN, 8'h1D, 8'h55, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_UP,   8'h1D, 8'hAA, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_DOWN, 8'h49, 8'hAA, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_UP,   8'h80, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b0, CMD_KEY_DOWN, 8'h7F, 8'h08, 2'd0, 8'h00, 8'h00, 8'h00},
		'{1'b1, CMD_KEY_UP,   8'hFF, 8'h00, 2'd3, PREFIX_EXT, PREFIX_BREAK, 8'h1F}
	};

	scan_t      pending_bytes [$];
	scan_t      out_want;
	logic [7:0] held_mods;
	int         mismatches;
	int         transfers;
	int         pop_hold;
	bit         pop_steady;

	hid_to_ps2_set2_scancode_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.command       (command),
		.key_usage     (key_usage),
		.modifier_bits (modifier_bits),
		.empty         (empty),
		.pop           (pop),
		.scan_byte     (scan_byte),
		.last_byte     (last_byte)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Translates one event into set 2 bytes and updates the held modifier
	// mask. When queue_bytes is clear only the mask is updated.
	function automatic void translate_event(input logic cmd, input logic [7:0] usage,
			input logic [7:0] mods, input bit queue_bytes);
		logic [7:0] key_seq [$];
		logic [7:0] mod_seq [$];
		logic [7:0] all_seq [$];
		logic [7:0] changed;
		logic [8:0] entry;
		scan_t      item;
		changed = mods ^ held_mods;
		entry = (usage < 8'd100) ? set2_code[usage] : 9'h000;

		// Key bytes: extended prefix, break prefix on release, then the code.
		if (entry != 9'h000) begin
			if (entry[8])
				key_seq.push_back(PREFIX_EXT);
			if (cmd == CMD_KEY_UP)
				key_seq.push_back(PREFIX_BREAK);
			key_seq.push_back(entry[7:0]);
		end

		// One make or break sequence per changed modifier, low bit first.
		for (int i = 0; i < 8; i++) begin
			if (changed[i]) begin
				if (hts2_pkg::MOD_EXT_MASK[i])
					mod_seq.push_back(PREFIX_EXT);
				if (!mods[i])
					mod_seq.push_back(PREFIX_BREAK);
				mod_seq.push_back(mod_make[i]);
			end
		end
		held_mods = mods;

		// Press sends modifiers first; release sends the key first.
		if (cmd == CMD_KEY_DOWN) begin
			foreach (mod_seq[i]) all_seq.push_back(mod_seq[i]);
			foreach (key_seq[i]) all_seq.push_back(key_seq[i]);
		end else begin
			foreach (key_seq[i]) all_seq.push_back(key_seq[i]);
			foreach (mod_seq[i]) all_seq.push_back(mod_seq[i]);
		end
		if (queue_bytes) begin
			foreach (all_seq[i]) begin
				item.code = all_seq[i];
				item.last = (i == all_seq.size() - 1);
				pending_bytes.push_back(item);
			end
		end
	endfunction

	// Holds the event on the inputs until the block takes it.
	task automatic send_event(input logic cmd, input logic [7:0] usage, input logic [7:0] mods);
		push <= 1'b1;
		command <= cmd;
		key_usage <= usage;
		modifier_bits <= mods;
		do @(posedge clk); while (full);
		translate_event(cmd, usage, mods, 1'b1);
	endtask

	// Output side: check each transfer, then maybe stall before the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: got byte %02h last %0b with nothing expected",
							$realtime, scan_byte, last_byte);
				end else begin
					out_want = pending_bytes.pop_front();
					if (scan_byte !== out_want.code || last_byte !== out_want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
								$realtime, out_want.code, out_want.last, scan_byte, last_byte);
					end
				end
				transfers++;
				if (transfers % 40 == 0)
					pop_steady = ($urandom_range(0, 3) == 0);
				pop_hold = pop_steady ? 0 : pick_gap();
			end else if (pop_hold > 0) begin
				pop_hold--;
			end
			pop <= (pop_hold == 0);
		end
	end

	// Stimulus: reset, directed table, then random key sequences.
	initial begin
		int         gap;
		int         r;
		bit         steady;
		bit         key_held;
		logic       c;
		logic [7:0] u;
		logic [7:0] m;
		logic [7:0] last_mods;
		logic [7:0] held_usage;
		event_row_t row;
		scan_t      item;

		arst_n <= 1'b0;
		push <= 1'b0;
		command <= CMD_KEY_DOWN;
		key_usage <= 8'h00;
		modifier_bits <= 8'h00;
		held_mods = 8'h00;
		mismatches = 0;
		transfers = 0;
		pop_hold = 0;
		pop_steady = 1'b0;
		steady = 1'b0;
		key_held = 1'b0;
		last_mods = 8'h00;
		held_usage = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table; rows with known bytes bypass the translator's output.
		for (int k = 0; k < DIRECTED_ROWS; k++) begin
			row = directed[k];
			push <= 1'b1;
			command <= row.cmd;
			key_usage <= row.usage;
			modifier_bits <= row.mods;
			do @(posedge clk); while (full);
			translate_event(row.cmd, row.usage, row.mods, !row.known);
			if (row.known) begin
				for (int i = 0; i < row.count; i++) begin
					item.code = (i == 0) ? row.b0 : (i == 1) ? row.b1 : row.b2;
					item.last = (i == row.count - 1);
					pending_bytes.push_back(item);
				end
			end
			gap = pick_gap();
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		last_mods = held_mods;

		// Random part: mostly press/release pairs with drifting modifiers.
		for (int k = 0; k < RANDOM_EVENTS; k++) begin
			if (k % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 8) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					m = last_mods;
				else if (r < 85)
					m = last_mods ^ (8'h01 << $urandom_range(0, 7));
				else
					m = 8'($urandom);
				if (key_held) begin
					c = CMD_KEY_UP;
					u = held_usage;
					key_held = 1'b0;
				end else begin
					c = CMD_KEY_DOWN;
					u = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(8'h04, 8'h63));
					held_usage = u;
					key_held = 1'b1;
				end
			end else begin
				c = 1'($urandom_range(0, 1));
				u = 8'($urandom);
				m = 8'($urandom);
			end
			last_mods = m;
			send_event(c, u, m);
			gap = steady ? 0 : pick_gap();
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;

		// Drain, then allow time for any stray bytes to show up.
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(10_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hts2_pkg.sv
sv/hts2_front.sv
sv/hts2_job_fifo.sv
sv/hts2_back.sv
sv/hid_to_ps2_set2_scancode_core.sv
sim/tb_hid_to_ps2_set2_scancode_core.sv
